FILE: design/tag_pkg.sv
`timescale 1ns / 1ps

package tag_pkg;

  // screen and texture limits
  localparam int SCREEN_WIDTH    = 800;
  localparam int SCREEN_HEIGHT   = 600;
  localparam int TEXTURE_DIM_MAX = 1024;

  // fixed point constants, Q16.16
  localparam int ONE_Q16  = 65536;
  localparam int HALF_Q16 = 32768;
  localparam int NORM_DIV = 255;
  localparam int FRAC_W   = 16;

  // field and datapath widths
  localparam int COORD_W = 10;                 // screen coordinate
  localparam int TEX_W   = 10;                 // texel coordinate
  localparam int IZ_W    = 20;                 // inverse zoom, Q4.16
  localparam int CAM_W   = 32;                 // camera position, Q16.16
  localparam int SZ_W    = 11;                 // texture size register
  localparam int MODE_W  = 4;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int E_W     = 13;                 // 2*s - screen size
  localparam int PROD_W  = E_W + IZ_W + 1;     // e * inverse_zoom
  localparam int C_W     = 35;                 // camera-relative position
  localparam int Q_W     = 28;                 // quotient by 255
  localparam int R_W     = 12;                 // remainder before correction
  localparam int U_W     = Q_W;                // normalized coordinate

  // stages from input register to normalized coordinate
  localparam int NORM_STAGES = 6;

  // register indexes
  localparam logic [IDX_W-1:0] REG_INVERSE_ZOOM   = 3'd0;
  localparam logic [IDX_W-1:0] REG_CAMERA_X       = 3'd1;
  localparam logic [IDX_W-1:0] REG_CAMERA_Y       = 3'd2;
  localparam logic [IDX_W-1:0] REG_TEXTURE_WIDTH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_TEXTURE_HEIGHT = 3'd4;
  localparam logic [IDX_W-1:0] REG_ADDRESS_MODE   = 3'd5;

  // address mode bits
  localparam int MODE_BORDER_Y = 0;
  localparam int MODE_BORDER_X = 1;
  localparam int MODE_EDGE_X   = 2;
  localparam int MODE_EDGE_Y   = 3;

  typedef struct packed {
    logic [COORD_W-1:0] screen_x;
    logic [COORD_W-1:0] screen_y;
  } pix_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_screen_x;
    logic [COORD_W-1:0] out_screen_y;
    logic [TEX_W-1:0]   texel_x;
    logic [TEX_W-1:0]   texel_y;
  } pix_out_t;

  // per axis settings for the normalize pipeline
  typedef struct packed {
    logic [IZ_W-1:0]         inverse_zoom;
    logic signed [CAM_W-1:0] camera;
  } norm_cfg_t;

  // per axis settings for the texel scaler
  typedef struct packed {
    logic [SZ_W-1:0] size;
    logic            edge_mode;
  } tex_cfg_t;

endpackage

FILE: design/tag_norm.sv
`timescale 1ns / 1ps

module tag_norm (
  input  logic                               clk,
  input  logic                               en,
  input  logic [tag_pkg::COORD_W-1:0]        screen,
  input  logic [tag_pkg::E_W-1:0]            screen_size,
  input  tag_pkg::norm_cfg_t                 cfg,
  output logic signed [tag_pkg::U_W-1:0]     u
);

  localparam int C_W = tag_pkg::C_W;
  localparam int Q_W = tag_pkg::Q_W;
  localparam int R_W = tag_pkg::R_W;
  localparam int U_W = tag_pkg::U_W;
  localparam int E_W = tag_pkg::E_W;

  localparam logic signed [R_W-1:0] D1 = R_W'(tag_pkg::NORM_DIV);
  localparam logic signed [R_W-1:0] D2 = R_W'(2 * tag_pkg::NORM_DIV);
  localparam logic signed [R_W-1:0] D3 = R_W'(3 * tag_pkg::NORM_DIV);
  localparam logic signed [R_W-1:0] D4 = R_W'(4 * tag_pkg::NORM_DIV);

  logic signed [E_W-1:0]              e;
  logic signed [tag_pkg::PROD_W-1:0]  prod;
  logic signed [C_W-1:0]              c3;
  logic signed [C_W-1:0]              c4;
  logic signed [Q_W-1:0]              q4;
  logic signed [Q_W-1:0]              q5;
  logic signed [R_W-1:0]              r5;

  logic [E_W-1:0]                     s2;
  logic signed [tag_pkg::PROD_W-1:0]  prod_half;
  logic signed [C_W-1:0]              c_next;
  logic signed [C_W-1:0]              q_full;
  logic signed [C_W-1:0]              q4_ext;
  logic signed [C_W-1:0]              r_full;
  logic [2:0]                         up_cnt;
  logic                               dn;

  // stage 1: centered coordinate, 2*s - size, in half pixels
  assign s2 = {{(E_W - tag_pkg::COORD_W - 1){1'b0}}, screen, 1'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      e <= $signed(s2 - screen_size);
    end
  end

  // stage 2: scale by inverse zoom
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= e * $signed({1'b0, cfg.inverse_zoom});
    end
  end

  // stage 3: floor halve and add camera
  assign prod_half = prod >>> 1;
  assign c_next = C_W'(prod_half) + C_W'(cfg.camera);

  always_ff @(posedge clk) begin
    if (en) begin
      c3 <= c_next;
    end
  end

  // stage 4: quotient estimate, c/255 as a sum of shifts by 256
  assign q_full = (c3 >>> 8) + (c3 >>> 16) + (c3 >>> 24) + (c3 >>> 32);

  always_ff @(posedge clk) begin
    if (en) begin
      c4 <= c3;
      q4 <= q_full[Q_W-1:0];
    end
  end

  // stage 5: remainder of the estimate, known to stay small
  assign q4_ext = C_W'(q4);
  assign r_full = c4 - (q4_ext <<< 8) + q4_ext;

  always_ff @(posedge clk) begin
    if (en) begin
      q5 <= q4;
      r5 <= r_full[R_W-1:0];
    end
  end

  // stage 6: correct the quotient and add one half
  assign up_cnt = 3'(r5 >= D1) + 3'(r5 >= D2) + 3'(r5 >= D3) + 3'(r5 >= D4);
  assign dn     = r5[R_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      u <= q5 + $signed(U_W'(up_cnt)) - $signed(U_W'(dn)) + $signed(U_W'(tag_pkg::HALF_Q16));
    end
  end

endmodule

FILE: design/tag_texel.sv
`timescale 1ns / 1ps

module tag_texel (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [tag_pkg::U_W-1:0]  u,
  input  tag_pkg::tex_cfg_t               cfg,
  output logic [tag_pkg::TEX_W-1:0]       texel
);

  localparam int U_W   = tag_pkg::U_W;
  localparam int F_W   = tag_pkg::FRAC_W;
  localparam int M_W   = F_W + tag_pkg::SZ_W;

  logic                       neg;
  logic                       at_top;
  logic [M_W-1:0]             scaled;
  logic [tag_pkg::SZ_W-1:0]   last;
  logic [tag_pkg::TEX_W-1:0]  texel_next;

  // range tests: below zero, at or above one
  assign neg    = u[U_W-1];
  assign at_top = !neg && (u[U_W-2:F_W] != '0);

  // wrap by the fraction and scale by the texture size
  assign scaled = M_W'(u[F_W-1:0]) * M_W'(cfg.size);
  assign last   = cfg.size - tag_pkg::SZ_W'(1);

  always_comb begin
    texel_next = scaled[F_W+tag_pkg::TEX_W-1:F_W];
    if (cfg.edge_mode && neg) begin
      texel_next = '0;
    end else if (cfg.edge_mode && at_top) begin
      texel_next = last[tag_pkg::TEX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      texel <= texel_next;
    end
  end

endmodule

FILE: design/texture_address_generator_core.sv
`timescale 1ns / 1ps

// channel  direction  handshake             payload
// in       input      in_valid / in_ready   in_data   (screen_x, screen_y)
// out      output     out_valid / out_ready out_data  (echo, texel_x, texel_y)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle while the output is not stalled; an accepted item reaches
// out_valid through the seven stage chain: center, zoom multiply, camera add, three
// stages of divide by 255, and the texel scale multiply
// items that fall outside a bordered axis leave the pipe with no result
// rst is synchronous, clears the valid bits and the registers to defaults
// and holds in_ready and cfg_ready low
// when out_valid is held and out_ready is low the whole pipe holds its state

module texture_address_generator_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tag_pkg::pix_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tag_pkg::pix_out_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tag_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tag_pkg::CFG_W-1:0]    cfg_data
);

  localparam int NS  = tag_pkg::NORM_STAGES;
  localparam int U_W = tag_pkg::U_W;
  localparam logic signed [U_W-1:0] U_ONE = U_W'(tag_pkg::ONE_Q16);

  logic [tag_pkg::IZ_W-1:0]          inverse_zoom;
  logic signed [tag_pkg::CAM_W-1:0]  camera_x;
  logic signed [tag_pkg::CAM_W-1:0]  camera_y;
  logic [tag_pkg::SZ_W-1:0]          texture_width;
  logic [tag_pkg::SZ_W-1:0]          texture_height;
  logic [tag_pkg::MODE_W-1:0]        address_mode;

  logic                              en;
  logic [NS-1:0]                     v;
  tag_pkg::pix_in_t                  echo [NS];
  tag_pkg::pix_in_t                  echo_out;
  logic                              out_valid_next;
  logic                              drop;
  logic                              oob_x;
  logic                              oob_y;
  logic signed [U_W-1:0]             u_x;
  logic signed [U_W-1:0]             u_y;
  logic [tag_pkg::TEX_W-1:0]         texel_x;
  logic [tag_pkg::TEX_W-1:0]         texel_y;
  tag_pkg::norm_cfg_t                norm_cfg_x;
  tag_pkg::norm_cfg_t                norm_cfg_y;
  tag_pkg::tex_cfg_t                 tex_cfg_x;
  tag_pkg::tex_cfg_t                 tex_cfg_y;

  // size zero acts as one, size above the limit acts as the limit
  function automatic logic [tag_pkg::SZ_W-1:0] eff_size(input logic [tag_pkg::SZ_W-1:0] sz);
    logic [tag_pkg::SZ_W-1:0] r;
    r = sz;
    if (sz == '0) begin
      r = tag_pkg::SZ_W'(1);
    end else if (sz > tag_pkg::SZ_W'(tag_pkg::TEXTURE_DIM_MAX)) begin
      r = tag_pkg::SZ_W'(tag_pkg::TEXTURE_DIM_MAX);
    end
    return r;
  endfunction

  // configuration registers
  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_zoom   <= tag_pkg::IZ_W'(tag_pkg::ONE_Q16);
      camera_x       <= '0;
      camera_y       <= '0;
      texture_width  <= tag_pkg::SZ_W'(256);
      texture_height <= tag_pkg::SZ_W'(256);
      address_mode   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tag_pkg::REG_INVERSE_ZOOM:   inverse_zoom   <= cfg_data[tag_pkg::IZ_W-1:0];
        tag_pkg::REG_CAMERA_X:       camera_x       <= $signed(cfg_data);
        tag_pkg::REG_CAMERA_Y:       camera_y       <= $signed(cfg_data);
        tag_pkg::REG_TEXTURE_WIDTH:  texture_width  <= cfg_data[tag_pkg::SZ_W-1:0];
        tag_pkg::REG_TEXTURE_HEIGHT: texture_height <= cfg_data[tag_pkg::SZ_W-1:0];
        tag_pkg::REG_ADDRESS_MODE:   address_mode   <= cfg_data[tag_pkg::MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // per axis settings
  assign norm_cfg_x = '{inverse_zoom: inverse_zoom, camera: camera_x};
  assign norm_cfg_y = '{inverse_zoom: inverse_zoom, camera: camera_y};
  assign tex_cfg_x  = '{size: eff_size(texture_width),
                        edge_mode: address_mode[tag_pkg::MODE_EDGE_X]};
  assign tex_cfg_y  = '{size: eff_size(texture_height),
                        edge_mode: address_mode[tag_pkg::MODE_EDGE_Y]};

  // global advance: the pipe moves unless a result is waiting and out_ready is low
  assign en       = !out_valid || out_ready;
  assign in_ready = en && !rst;

  // valid bits and screen echo travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      echo[0] <= in_data;
      for (int i = 1; i < NS; i++) begin
        echo[i] <= echo[i-1];
      end
      echo_out <= echo[NS-1];
    end
  end

  // normalize pipelines, one per axis
  tag_norm u_norm_x (
    .clk         (clk),
    .en          (en),
    .screen      (in_data.screen_x),
    .screen_size (tag_pkg::E_W'(tag_pkg::SCREEN_WIDTH)),
    .cfg         (norm_cfg_x),
    .u           (u_x)
  );

  tag_norm u_norm_y (
    .clk         (clk),
    .en          (en),
    .screen      (in_data.screen_y),
    .screen_size (tag_pkg::E_W'(tag_pkg::SCREEN_HEIGHT)),
    .cfg         (norm_cfg_y),
    .u           (u_y)
  );

  // border discard, tested before any clamp
  assign oob_x = (u_x < 0) || (u_x > U_ONE);
  assign oob_y = (u_y < 0) || (u_y > U_ONE);
  assign drop  = (address_mode[tag_pkg::MODE_BORDER_X] && oob_x) ||
                 (address_mode[tag_pkg::MODE_BORDER_Y] && oob_y);
  assign out_valid_next = v[NS-1] && !drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= out_valid_next;
    end
  end

  // texel scale, registered inside
  tag_texel u_texel_x (
    .clk   (clk),
    .en    (en),
    .u     (u_x),
    .cfg   (tex_cfg_x),
    .texel (texel_x)
  );

  tag_texel u_texel_y (
    .clk   (clk),
    .en    (en),
    .u     (u_y),
    .cfg   (tex_cfg_y),
    .texel (texel_y)
  );

  assign out_data = '{out_screen_x: echo_out.screen_x,
                      out_screen_y: echo_out.screen_y,
                      texel_x: texel_x,
                      texel_y: texel_y};

  // checks
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v[0])
    else $error("accepted item did not enter the pipe");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> ($stable(v) && out_valid))
    else $error("pipe moved during a stall");

  a_drop_result: assert property (@(posedge clk) disable iff (rst)
    (en && v[NS-1]) |=> (out_valid == !$past(drop)))
    else $error("border discard and result valid disagree");

endmodule

FILE: dv/texture_address_checker.sv
`timescale 1ns / 1ps

module texture_address_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  tag_pkg::pix_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  tag_pkg::pix_out_t         out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [tag_pkg::IDX_W-1:0] cfg_index,
  input  logic [tag_pkg::CFG_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending_results,
  output int                        texels_checked,
  output int                        pixels_discarded
);
  import tag_pkg::*;

  // shadow copy of the addressing registers
  logic [IZ_W-1:0]         zoom_inv   = 20'd65536;
  logic signed [CAM_W-1:0] cam_x      = '0;
  logic signed [CAM_W-1:0] cam_y      = '0;
  logic [SZ_W-1:0]         tex_w      = 11'd256;
  logic [SZ_W-1:0]         tex_h      = 11'd256;
  logic [MODE_W-1:0]       addr_mode  = '0;

  // texel addresses predicted for pixels in flight, oldest first
  pix_out_t texel_fetch_q[$];

  int fails     = 0;
  int checked   = 0;
  int discarded = 0;

  // normalized coordinate u, Q16.16, floor rounding at both divides
  function automatic longint norm_axis(input logic [COORD_W-1:0] s, input int scr,
                                       input logic [IZ_W-1:0] iz,
                                       input logic signed [CAM_W-1:0] cam);
    longint d;
    longint c;
    longint q;
    d = longint'(s) * ONE_Q16 - longint'(scr) * HALF_Q16;
    c = ((d * longint'(iz)) >>> FRAC_W) + longint'(cam);
    if (c >= 0) q = c / NORM_DIV;
    else q = -((-c + NORM_DIV - 1) / NORM_DIV);
    return q + HALF_Q16;
  endfunction

  // texture size as the block uses it
  function automatic longint clip_size(input logic [SZ_W-1:0] r);
    if (r == 0) return 1;
    if (r > TEXTURE_DIM_MAX) return TEXTURE_DIM_MAX;
    return longint'(r);
  endfunction

  // clamp on edge axes, then wrap and scale to the texture
  function automatic logic [TEX_W-1:0] texel_of(input longint u, input bit edge_on,
                                                input longint sz);
    longint v;
    v = u;
    if (edge_on) begin
      if (v < 0) v = 0;
      if (v > ONE_Q16) v = ONE_Q16;
      // exactly 1.0 after the clamp lands on the last texel
      if (v == ONE_Q16) return TEX_W'(sz - 1);
    end
    return TEX_W'(((v & 64'hFFFF) * sz) >> FRAC_W);
  endfunction

  // returns 0 when a bordered axis discards the pixel
  function automatic bit predict_texel_fetch(input pix_in_t px, output pix_out_t res);
    longint ux;
    longint uy;
    ux = norm_axis(px.screen_x, SCREEN_WIDTH, zoom_inv, cam_x);
    uy = norm_axis(px.screen_y, SCREEN_HEIGHT, zoom_inv, cam_y);
    res = '0;
    if (addr_mode[MODE_BORDER_Y] && (uy < 0 || uy > ONE_Q16)) return 0;
    if (addr_mode[MODE_BORDER_X] && (ux < 0 || ux > ONE_Q16)) return 0;
    res.out_screen_x = px.screen_x;
    res.out_screen_y = px.screen_y;
    res.texel_x      = texel_of(ux, addr_mode[MODE_EDGE_X], clip_size(tex_w));
    res.texel_y      = texel_of(uy, addr_mode[MODE_EDGE_Y], clip_size(tex_h));
    return 1;
  endfunction

  function automatic int field_differs(input string name, input int want, input int got);
    if (want == got) return 0;
    $error("%s mismatch: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  // watch the three channels, predict and compare
  always @(posedge clk) begin : watch
    pix_out_t want;
    pix_out_t fresh;
    int bad;
    if (rst) begin
      zoom_inv  = 20'd65536;
      cam_x     = '0;
      cam_y     = '0;
      tex_w     = 11'd256;
      tex_h     = 11'd256;
      addr_mode = '0;
      texel_fetch_q.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INVERSE_ZOOM:   zoom_inv  = cfg_data[IZ_W-1:0];
          REG_CAMERA_X:       cam_x     = cfg_data;
          REG_CAMERA_Y:       cam_y     = cfg_data;
          REG_TEXTURE_WIDTH:  tex_w     = cfg_data[SZ_W-1:0];
          REG_TEXTURE_HEIGHT: tex_h     = cfg_data[SZ_W-1:0];
          REG_ADDRESS_MODE:   addr_mode = cfg_data[MODE_W-1:0];
          default: ;
        endcase
      end
      // result side, compared against the oldest prediction
      if (out_valid && out_ready) begin
        if (texel_fetch_q.size() == 0) begin
          $error("texel address (%0d,%0d) for pixel (%0d,%0d) with no pixel waiting",
                 out_data.texel_x, out_data.texel_y,
                 out_data.out_screen_x, out_data.out_screen_y);
          fails++;
        end else begin
          want = texel_fetch_q.pop_front();
          bad  = field_differs("out_screen_x", want.out_screen_x, out_data.out_screen_x);
          bad += field_differs("out_screen_y", want.out_screen_y, out_data.out_screen_y);
          bad += field_differs("texel_x", want.texel_x, out_data.texel_x);
          bad += field_differs("texel_y", want.texel_y, out_data.texel_y);
          if (bad != 0) fails++;
          checked++;
        end
      end
      // pixel side
      if (in_valid && in_ready) begin
        if (predict_texel_fetch(in_data, fresh)) texel_fetch_q.push_back(fresh);
        else discarded++;
      end
    end
    fail_count       <= fails;
    pending_results  <= texel_fetch_q.size();
    texels_checked   <= checked;
    pixels_discarded <= discarded;
  end

endmodule

FILE: dv/tb_texture_address_generator_core.sv
`timescale 1ns / 1ps

module tb_texture_address_generator_core;
  import tag_pkg::*;

  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_PIXELS   = 125;
  localparam int CAM_SPAN       = 400 * ONE_Q16;

  typedef struct packed {
    logic [IZ_W-1:0]   inverse_zoom;
    logic [CAM_W-1:0]  camera_x;
    logic [CAM_W-1:0]  camera_y;
    logic [SZ_W-1:0]   texture_width;
    logic [SZ_W-1:0]   texture_height;
    logic [MODE_W-1:0] address_mode;
  } addr_setup_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  pix_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  pix_out_t          out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;

  int fail_count;
  int pending_results;
  int texels_checked;
  int pixels_discarded;

  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int rx_hold_asked = 0;
  int rx_hold_taken = 0;
  int rx_hold_left  = 0;
  int quiet_cycles  = 0;
  int pixels_sent   = 0;
  int setups_loaded = 0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  texture_address_generator_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  texture_address_checker addr_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending_results  (pending_results),
    .texels_checked   (texels_checked),
    .pixels_discarded (pixels_discarded)
  );

  // result side: random stalls, plus a long hold when asked
  always @(posedge clk) begin
    if (rx_hold_taken != rx_hold_asked) begin
      rx_hold_taken <= rx_hold_asked;
      rx_hold_left  <= HOLD_CYCLES;
      out_ready     <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready    <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one pixel item, with random idle cycles in front of it
  task automatic offer_pixel(input int x, input int y);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{screen_x: COORD_W'(x), screen_y: COORD_W'(y)};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // stop offering until every predicted address is back and the pipe is empty
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all six addressing registers
  task automatic load_addressing(input addr_setup_t s);
    logic [IDX_W-1:0] regs [6];
    logic [CFG_W-1:0] vals [6];
    regs = '{REG_INVERSE_ZOOM, REG_CAMERA_X, REG_CAMERA_Y,
             REG_TEXTURE_WIDTH, REG_TEXTURE_HEIGHT, REG_ADDRESS_MODE};
    vals = '{CFG_W'(s.inverse_zoom), s.camera_x, s.camera_y,
             CFG_W'(s.texture_width), CFG_W'(s.texture_height), CFG_W'(s.address_mode)};
    cfg_valid <= 1'b1;
    for (int i = 0; i < 6; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    setups_loaded++;
  endtask

  function automatic addr_setup_t make_setup(input int iz, input int cx, input int cy,
                                             input int tw, input int th, input int mode);
    addr_setup_t s;
    s.inverse_zoom   = IZ_W'(iz);
    s.camera_x       = CAM_W'(cx);
    s.camera_y       = CAM_W'(cy);
    s.texture_width  = SZ_W'(tw);
    s.texture_height = SZ_W'(th);
    s.address_mode   = MODE_W'(mode);
    return s;
  endfunction

  // camera mostly near the screen, sometimes anywhere
  function automatic int random_camera();
    if ($urandom_range(7) == 0) return int'($urandom);
    return int'($urandom_range(2 * CAM_SPAN)) - CAM_SPAN;
  endfunction

  // sizes mostly legal, sometimes zero or above the maximum
  function automatic int random_size();
    if ($urandom_range(7) == 0) return $urandom_range(2047);
    return $urandom_range(1, TEXTURE_DIM_MAX);
  endfunction

  function automatic addr_setup_t random_setup();
    int iz;
    case ($urandom_range(9))
      0:       iz = 1024;
      1:       iz = 655360;
      2:       iz = 0;
      default: iz = $urandom_range(1024, 262144);
    endcase
    return make_setup(iz, random_camera(), random_camera(), random_size(), random_size(),
                      $urandom_range(15));
  endfunction

  // stimulus
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset defaults, corners, center and off-screen pixels
    tx_idle_pct = 21;
    rx_idle_pct = 87;
    offer_pixel(0, 0);
    offer_pixel(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
    offer_pixel(SCREEN_WIDTH / 2, SCREEN_HEIGHT / 2);
    offer_pixel(1023, 1023);
    offer_pixel(0, SCREEN_HEIGHT - 1);
    offer_pixel(SCREEN_WIDTH - 1, 0);
    wait_for_quiet();

    // edge clamp with the center at exactly 1.0, zero and oversized texture
    load_addressing(make_setup(ONE_Q16, NORM_DIV * HALF_Q16, NORM_DIV * HALF_Q16,
                               0, 2047, 4'hC));
    offer_pixel(SCREEN_WIDTH / 2, SCREEN_HEIGHT / 2);
    offer_pixel(0, 0);
    offer_pixel(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1);
    wait_for_quiet();

    // all modes on: 1.0 survives the border test, one step past it does not
    load_addressing(make_setup(ONE_Q16, NORM_DIV * HALF_Q16, NORM_DIV * HALF_Q16,
                               7, 1000, 4'hF));
    offer_pixel(SCREEN_WIDTH / 2, SCREEN_HEIGHT / 2);
    offer_pixel(SCREEN_WIDTH / 2 + 1, SCREEN_HEIGHT / 2);
    offer_pixel(SCREEN_WIDTH / 2, SCREEN_HEIGHT / 2 + 1);
    offer_pixel(0, 0);
    wait_for_quiet();

    // zero zoom register with extreme cameras
    load_addressing(make_setup(0, 32'h7FFF_FFFF, 32'h8000_0000, TEXTURE_DIM_MAX, 1, 0));
    offer_pixel(0, 0);
    offer_pixel(1023, 1023);
    wait_for_quiet();

    // widest zoom field value, border y with edge x
    load_addressing(make_setup(20'hFFFFF, 0, 0, 3, 640, 4'h5));
    offer_pixel(0, SCREEN_HEIGHT / 2);
    offer_pixel(512, SCREEN_HEIGHT / 2);
    offer_pixel(SCREEN_WIDTH - 1, 0);
    wait_for_quiet();

    // random phases under three idling regimes
    for (int ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        tx_idle_pct = 21;
        rx_idle_pct = 87;
      end else if (ph < 6) begin
        tx_idle_pct = 87;
        rx_idle_pct = 21;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (ph == 0)
        load_addressing(make_setup(1024, 32'h8000_0000, 32'h8000_0000, 1, 1, 0));
      else if (ph == 1)
        load_addressing(make_setup(655360, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                   TEXTURE_DIM_MAX, TEXTURE_DIM_MAX, 4'hC));
      else
        load_addressing(random_setup());
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        // long result stall while pixels keep coming, so the pipe backs up
        if (ph == 6 && n == 30) rx_hold_asked++;
        if ($urandom_range(9) == 0)
          offer_pixel($urandom_range(1023), $urandom_range(1023));
        else
          offer_pixel($urandom_range(SCREEN_WIDTH - 1), $urandom_range(SCREEN_HEIGHT - 1));
      end
      wait_for_quiet();
    end

    $display("summary: %0d pixels over %0d register setups plus reset defaults",
             pixels_sent, setups_loaded);
    $display("summary: %0d texel addresses checked, %0d pixels discarded at a border",
             texels_checked, pixels_discarded);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
